[sv/iidl_pkg.sv]
// Shared types and codes for the indexed insert/delete list.
`timescale 1ns / 1ps
package iidl_pkg;

   // request opcodes
   localparam logic [2:0] OP_INSERT   = 3'd0;
   localparam logic [2:0] OP_APPEND   = 3'd1;
   localparam logic [2:0] OP_DEL_AT   = 3'd2;
   localparam logic [2:0] OP_DEL_LAST = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;

   // response status codes
   localparam logic [1:0] STS_OK     = 2'd0;
   localparam logic [1:0] STS_FULL   = 2'd1;
   localparam logic [1:0] STS_EMPTY  = 2'd2;
   localparam logic [1:0] STS_BADIDX = 2'd3;

   // cell actions, broadcast to every cell of the chain
   localparam logic [1:0] ACT_HOLD       = 2'd0;
   localparam logic [1:0] ACT_SHIFT_UP   = 2'd1;
   localparam logic [1:0] ACT_WRITE      = 2'd2;
   localparam logic [1:0] ACT_SHIFT_DOWN = 2'd3;

   // index width for the largest supported list (1024 entries plus the full count)
   localparam int TGT_W = 11;

   typedef struct packed {
      logic [31:0] tag;
      logic [15:0] count;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   typedef struct packed {
      logic [1:0]       action;
      logic [TGT_W-1:0] target;
      entry_type        entry;
   } cell_ctrl_type;

endpackage

[sv/iidl_cell.sv]
// One list slot: holds an entry and takes it from a neighbor on a shift.
`timescale 1ns / 1ps
module iidl_cell #(
   parameter int INDEX = 0
) (
   input  logic                       clock,
   input  iidl_pkg::cell_ctrl_type    ctrl,
   input  iidl_pkg::entry_type        lower_data,
   input  iidl_pkg::entry_type        upper_data,
   input  logic                       rd_en,
   input  logic [iidl_pkg::TGT_W-1:0] rd_pos,
   output iidl_pkg::entry_type        data_out,
   output iidl_pkg::entry_type        rd_data
);

   localparam logic [iidl_pkg::TGT_W-1:0] MY_IDX = iidl_pkg::TGT_W'(INDEX);

   iidl_pkg::entry_type data_ff;
   iidl_pkg::entry_type data_in;

   always_comb begin
      data_in = data_ff;
      case (ctrl.action)
         iidl_pkg::ACT_SHIFT_UP: begin
            if (MY_IDX > ctrl.target) begin
               data_in = lower_data;
            end else if (MY_IDX == ctrl.target) begin
               data_in = ctrl.entry;
            end
         end
         iidl_pkg::ACT_WRITE: begin
            if (MY_IDX == ctrl.target) begin
               data_in = ctrl.entry;
            end
         end
         iidl_pkg::ACT_SHIFT_DOWN: begin
            if (MY_IDX >= ctrl.target) begin
               data_in = upper_data;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data_out = data_ff;
   // only the addressed cell drives nonzero data into the read tree
   assign rd_data  = (rd_en && (rd_pos == MY_IDX)) ? data_ff : '0;

endmodule

[sv/iidl_or_tree.sv]
// Registered OR-reduction tree, eight inputs per node, one register level per stage.
`timescale 1ns / 1ps
module iidl_or_tree #(
   parameter int N      = 128,
   parameter int W      = 48,
   parameter int LEVELS = 3
) (
   input  logic         clock,
   input  logic [W-1:0] din [N],
   output logic [W-1:0] dout
);

   logic [W-1:0] lvl_ff [LEVELS][N];
   logic [W-1:0] lvl_in [LEVELS][N];

   always_comb begin
      for (int k = 0; k < LEVELS; k++) begin
         for (int j = 0; j < N; j++) begin
            lvl_in[k][j] = '0;
            for (int m = 0; m < 8; m++) begin
               if (j * 8 + m < N) begin
                  if (k == 0) begin
                     lvl_in[k][j] = lvl_in[k][j] | din[j * 8 + m];
                  end else begin
                     lvl_in[k][j] = lvl_in[k][j] | lvl_ff[(k > 0) ? k - 1 : 0][j * 8 + m];
                  end
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      lvl_ff <= lvl_in;
   end

   assign dout = lvl_ff[LEVELS-1][0];

endmodule

[sv/indexed_insert_delete_list_core.sv]
// Top level of the indexed insert/delete list: control, length tracking and the cell chain.
`timescale 1ns / 1ps
// Ordered list of up to DEPTH entries (32-bit tag, 16-bit count) kept in a row of cells.
// Insert and delete move every later entry one place at once, all cells together; each request
// returns one response with status and the new length. The wait counter is loaded with
// LEVELS = ceil(log8(DEPTH)) (3 for 128 entries), the number of levels of the registered
// eight-way OR tree that brings the addressed entry out for a read; all opcodes wait the
// same way. A new request is accepted once the previous one has reached the response
// register, so requests do not overlap. Stored entries have no reset; only the length
// and control are cleared.
module indexed_insert_delete_list_core #(
   parameter int DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_opcode,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_entry_tag,
   input  logic [15:0] req_entry_count,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_length,
   output logic [31:0] rsp_read_tag,
   output logic [15:0] rsp_read_count
);

   localparam int LW     = $clog2(DEPTH + 1);
   localparam int TW     = iidl_pkg::TGT_W;
   localparam int EW     = iidl_pkg::ENTRY_W;
   localparam int LEVELS = ($clog2(DEPTH) + 2) / 3;
   localparam int CW     = $clog2(LEVELS + 1);

   localparam logic S_IDLE = 1'b0;
   localparam logic S_RUN  = 1'b1;

   logic                state_ff, state_in;
   logic [CW-1:0]       wait_ff, wait_in;
   logic [LW-1:0]       length_ff, length_in;
   logic [1:0]          status_ff, status_in;
   logic                rd_en_ff, rd_en_in;
   logic [TW-1:0]       rd_pos_ff, rd_pos_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [1:0]          rsp_status_ff;
   logic [7:0]          rsp_length_ff;
   iidl_pkg::entry_type rsp_entry_ff;

   logic                accept;
   logic                out_free;
   logic                finish;
   logic                full, empty;
   logic [TW-1:0]       len_ext, pos_ext;
   iidl_pkg::cell_ctrl_type ctrl;

   iidl_pkg::entry_type cell_data [DEPTH];
   logic [EW-1:0]       tree_in [DEPTH];
   logic [EW-1:0]       tree_out;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign finish    = (state_ff == S_RUN) && (wait_ff == '0) && out_free;

   assign full    = (length_ff == LW'(DEPTH));
   assign empty   = (length_ff == '0);
   assign len_ext = TW'(length_ff);
   assign pos_ext = TW'(req_position);

   // decode the request, work out the status and the cell action
   always_comb begin
      status_in         = status_ff;
      length_in         = length_ff;
      rd_en_in          = rd_en_ff;
      rd_pos_in         = rd_pos_ff;
      ctrl.action       = iidl_pkg::ACT_HOLD;
      ctrl.target       = pos_ext;
      ctrl.entry.tag    = req_entry_tag;
      ctrl.entry.count  = req_entry_count;
      if (accept) begin
         status_in = iidl_pkg::STS_OK;
         rd_en_in  = 1'b0;
         rd_pos_in = pos_ext;
         case (req_opcode)
            iidl_pkg::OP_INSERT: begin
               if (full) begin
                  status_in = iidl_pkg::STS_FULL;
               end else if (pos_ext > len_ext) begin
                  status_in = iidl_pkg::STS_BADIDX;
               end else begin
                  ctrl.action = iidl_pkg::ACT_SHIFT_UP;
                  length_in   = length_ff + 1'b1;
               end
            end
            iidl_pkg::OP_APPEND: begin
               if (full) begin
                  status_in = iidl_pkg::STS_FULL;
               end else begin
                  ctrl.action = iidl_pkg::ACT_WRITE;
                  ctrl.target = len_ext;
                  length_in   = length_ff + 1'b1;
               end
            end
            iidl_pkg::OP_DEL_AT: begin
               if (empty) begin
                  status_in = iidl_pkg::STS_EMPTY;
               end else if (pos_ext >= len_ext) begin
                  status_in = iidl_pkg::STS_BADIDX;
               end else begin
                  ctrl.action = iidl_pkg::ACT_SHIFT_DOWN;
                  length_in   = length_ff - 1'b1;
               end
            end
            iidl_pkg::OP_DEL_LAST: begin
               if (empty) begin
                  status_in = iidl_pkg::STS_EMPTY;
               end else begin
                  length_in = length_ff - 1'b1;
               end
            end
            iidl_pkg::OP_READ: begin
               if (empty) begin
                  status_in = iidl_pkg::STS_EMPTY;
               end else if (pos_ext >= len_ext) begin
                  status_in = iidl_pkg::STS_BADIDX;
               end else begin
                  rd_en_in = 1'b1;
               end
            end
            default: begin
               status_in = iidl_pkg::STS_OK;
            end
         endcase
      end
   end

   always_comb begin
      state_in = state_ff;
      wait_in  = wait_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               state_in = S_RUN;
               wait_in  = CW'(LEVELS);
            end
         end
         S_RUN: begin
            if (wait_ff != '0) begin
               wait_in = wait_ff - 1'b1;
            end else if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         wait_ff      <= '0;
         length_ff    <= '0;
         rsp_valid_ff <= 1'b0;
         rd_en_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wait_ff      <= wait_in;
         length_ff    <= length_in;
         rsp_valid_ff <= rsp_valid_in;
         rd_en_ff     <= rd_en_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      rd_pos_ff <= rd_pos_in;
      if (finish) begin
         rsp_status_ff <= status_ff;
         rsp_length_ff <= 8'(length_ff);
         rsp_entry_ff  <= tree_out;
      end
   end

   // the cell chain
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      iidl_pkg::entry_type lower, upper;

      if (i == 0) begin : g_first
         assign lower = '0;
      end else begin : g_lower
         assign lower = cell_data[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign upper = '0;
      end else begin : g_upper
         assign upper = cell_data[i+1];
      end

      iidl_cell #(
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .lower_data (lower),
         .upper_data (upper),
         .rd_en      (rd_en_ff),
         .rd_pos     (rd_pos_ff),
         .data_out   (cell_data[i]),
         .rd_data    (tree_in[i])
      );
   end

   iidl_or_tree #(
      .N      (DEPTH),
      .W      (EW),
      .LEVELS (LEVELS)
   ) u_tree (
      .clock (clock),
      .din   (tree_in),
      .dout  (tree_out)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_length     = rsp_length_ff;
   assign rsp_read_tag   = rsp_entry_ff.tag;
   assign rsp_read_count = rsp_entry_ff.count;

endmodule
